// File: src/scc_pkg.sv
`default_nettype none

package scc_pkg;

    // data qubit grid limits
    localparam logic [3:0] MAX_DISTANCE   = 4'd15;
    localparam logic [3:0] DIST_RESET     = 4'd3;
    localparam int         TABLE_DEPTH_DEF = 256;
    localparam int         WALK_LIMIT     = 15;

    // command codes
    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_WALK  = 1'b1;

    // register index (paddr[2])
    localparam logic REG_CODE_DISTANCE = 1'b0;

    typedef struct packed {
        logic       command;
        logic [7:0] first_defect;
        logic [7:0] second_defect;
        logic       to_boundary;
    } t_cmd_word;

    typedef struct packed {
        logic [7:0] qubit_index;
        logic       apply_flip;
        logic       flip_kind;
        logic       error_flag;
        logic [7:0] stabilizer_total;
        logic       last;
    } t_result_word;

    typedef enum logic {
        OP_SCAN = 1'b0,
        OP_WALK = 1'b1
    } t_unit_op;

    typedef struct packed {
        t_unit_op   op;
        logic [3:0] distance;
        logic [4:0] px;
        logic [4:0] py;
        logic [3:0] tx;
        logic [3:0] ty;
        logic       bnd;
        logic       is_x;
    } t_unit_req;

    typedef struct packed {
        logic       kept;
        logic [4:0] nx;
        logic [4:0] ny;
        logic [7:0] qubit;
        logic       ok;
        logic       done_now;
        logic       done_next;
    } t_unit_rsp;

endpackage

`default_nettype wire

// File: src/scc_ram.sv
`default_nettype none

module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/scc_step_unit.sv
`default_nettype none

// Shared unit: corner keep test during the scan, one diagonal step during a walk.
module scc_step_unit (
    input  wire scc_pkg::t_unit_req i_req,
    output      scc_pkg::t_unit_rsp o_rsp
);

    logic [3:0] d;
    logic [4:0] d5;
    logic [3:0] sx, sy;
    logic       lx, rx, ty_in, by_in, n4, n2, corner_x, keep;
    logic       dxneg, dyneg;
    logic [4:0] qx, qy, nx, ny, tx5, ty5;
    logic       okx, oky, ok;
    logic [7:0] prod, qubit;
    logic       done_now, done_next;

    assign d   = i_req.distance;
    assign d5  = {1'b0, d};
    assign sx  = i_req.px[3:0];
    assign sy  = i_req.py[3:0];
    assign tx5 = {1'b0, i_req.tx};
    assign ty5 = {1'b0, i_req.ty};

    // neighbors of a corner: columns x-1 / x, rows y-1 / y
    assign lx    = (sx != 4'd0) && (sx <= d);
    assign rx    = sx < d;
    assign ty_in = (sy != 4'd0) && (sy <= d);
    assign by_in = sy < d;
    assign n4    = lx & rx & ty_in & by_in;
    assign n2    = (lx & rx & (ty_in ^ by_in)) | (ty_in & by_in & (lx ^ rx));
    assign corner_x = ~(sx[0] ^ sy[0]);
    assign keep  = (corner_x == i_req.is_x) &&
                   (n4 || (n2 && !(corner_x && ((sx == 4'd0) || (sx == d))) &&
                                 !(!corner_x && ((sy == 4'd0) || (sy == d)))));

    // step direction
    always_comb begin
        if (i_req.bnd) begin
            if (i_req.is_x) begin
                dxneg = tx5 <= i_req.px;
                dyneg = 1'b0;
            end else begin
                dxneg = 1'b0;
                dyneg = ty5 <= i_req.py;
            end
        end else begin
            dxneg = tx5 < i_req.px;
            dyneg = ty5 < i_req.py;
        end
    end

    assign qx  = i_req.px - {4'd0, dxneg};
    assign qy  = i_req.py - {4'd0, dyneg};
    assign okx = !(dxneg && (i_req.px == 5'd0)) && (qx < d5);
    assign oky = !(dyneg && (i_req.py == 5'd0)) && (qy < d5);
    assign ok  = okx & oky;
    assign nx  = dxneg ? (i_req.px - 5'd1) : (i_req.px + 5'd1);
    assign ny  = dyneg ? (i_req.py - 5'd1) : (i_req.py + 5'd1);

    assign prod  = {4'd0, qy[3:0]} * {4'd0, d};
    assign qubit = ok ? (prod + {3'd0, qx}) : 8'd0;

    // end of walk: boundary walks stop on one axis, pair walks on both
    always_comb begin
        if (i_req.bnd) begin
            done_now  = i_req.is_x ? (i_req.px == tx5) : (i_req.py == ty5);
            done_next = i_req.is_x ? (nx == tx5) : (ny == ty5);
        end else begin
            done_now  = (i_req.px == tx5) && (i_req.py == ty5);
            done_next = (nx == tx5) && (ny == ty5);
        end
    end

    always_comb begin
        o_rsp = '0;
        unique case (i_req.op)
            scc_pkg::OP_SCAN: begin
                o_rsp.kept = keep;
            end
            scc_pkg::OP_WALK: begin
                o_rsp.nx        = nx;
                o_rsp.ny        = ny;
                o_rsp.qubit     = qubit;
                o_rsp.ok        = ok;
                o_rsp.done_now  = done_now;
                o_rsp.done_next = done_next;
            end
            default: o_rsp = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: src/surface_code_correction_path_top.sv
`default_nettype none

// Rotated surface code correction chain engine.
// Command channel: a word on i_cmd is taken when start is high and busy low.
//   command build: scans the (d+1)x(d+1) corner grid twice (X pass, Z pass),
//     one corner per cycle, storing kept corners in the corner table RAM.
//     After both passes, one result word carries the stored count.
//   command walk: checks indexes and types at once (a rejected word gives one
//     error result the next cycle), else reads both corners from the table RAM
//     (states READ_A, READ_B, LOAD_B through its registered read port), then
//     emits one result word per cycle, one per diagonal step, up to 15 steps;
//     last marks the final.
// Result channel: o_result is valid for exactly one cycle with o_result_valid;
//   the receiver cannot stall, so results never back up.
// Busy stays high from acceptance until the final result is in the output
//   register; the next word can be taken in the cycle that result is shown.
// Config: APB register code_distance at byte 0; writing it drops the layout.
// Reset: d = 3, no layout built, counts zero; table contents stay undefined
//   and are never read before a build writes them.
module surface_code_correction_path_top #(
    parameter int TABLE_DEPTH = scc_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output      logic                 busy,
    input  wire scc_pkg::t_cmd_word   i_cmd,
    output      logic                 o_result_valid,
    output      scc_pkg::t_result_word o_result,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output      logic [31:0]          prdata,
    output      logic                 pready
);

    localparam int         AW        = $clog2(TABLE_DEPTH);
    localparam logic [8:0] DEPTH_LIM = 9'(TABLE_DEPTH);
    localparam logic [3:0] K_LAST    = 4'(scc_pkg::WALK_LIMIT - 1);
    localparam logic [7:0] QUBIT_MAX = 8'd224;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_READ_A = 6'b000100,
        S_READ_B = 6'b001000,
        S_LOAD_B = 6'b010000,
        S_WALK   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // architectural state
    logic [3:0] r_dist, n_dist;
    logic       r_built, n_built;
    logic [7:0] r_xcount, n_xcount;
    logic [7:0] r_total, n_total;     // also the running count during a build

    // scan position
    logic [3:0] r_sx, n_sx;
    logic [3:0] r_sy, n_sy;
    logic       r_pass, n_pass;

    // walk context
    logic [AW-1:0] r_a_addr, n_a_addr;
    logic [AW-1:0] r_b_addr, n_b_addr;
    logic          r_bnd, n_bnd;
    logic          r_is_x, n_is_x;
    logic [4:0]    r_cx, n_cx;
    logic [4:0]    r_cy, n_cy;
    logic [3:0]    r_tx, n_tx;
    logic [3:0]    r_ty, n_ty;
    logic [3:0]    r_k, n_k;

    // output register
    logic                  r_out_valid, n_out_valid;
    scc_pkg::t_result_word r_out, n_out;

    logic                 w_accept, w_cfg_wr;
    logic [3:0]           w_dist;
    logic                 w_range_err, w_type_err, w_a_is_x;
    logic                 w_we;
    logic [AW-1:0]        w_raddr;
    logic [7:0]           w_rdata;
    logic [7:0]           w_cnt_next;
    logic                 w_near_lo;
    logic                 w_last;
    scc_pkg::t_unit_req   w_req;
    scc_pkg::t_unit_rsp   w_rsp;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[2] == scc_pkg::REG_CODE_DISTANCE);
    assign w_dist   = (r_dist > scc_pkg::MAX_DISTANCE) ? scc_pkg::MAX_DISTANCE : r_dist;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == scc_pkg::REG_CODE_DISTANCE) ? {28'd0, r_dist} : 32'd0;

    // index checks at acceptance
    assign w_a_is_x    = i_cmd.first_defect < r_xcount;
    assign w_range_err = !r_built || (i_cmd.first_defect >= r_total) ||
                         (!i_cmd.to_boundary && (i_cmd.second_defect >= r_total));
    assign w_type_err  = !i_cmd.to_boundary &&
                         ((i_cmd.second_defect < r_xcount) != w_a_is_x);

    // shared unit: scan coordinates during a build, chain position during a walk
    always_comb begin
        w_req.distance = w_dist;
        w_req.tx   = r_tx;
        w_req.ty   = r_ty;
        if (r_state == S_SCAN) begin
            w_req.op   = scc_pkg::OP_SCAN;
            w_req.px   = {1'b0, r_sx};
            w_req.py   = {1'b0, r_sy};
            w_req.bnd  = 1'b0;
            w_req.is_x = !r_pass;
        end else begin
            w_req.op   = scc_pkg::OP_WALK;
            w_req.px   = r_cx;
            w_req.py   = r_cy;
            w_req.bnd  = r_bnd;
            w_req.is_x = r_is_x;
        end
    end

    scc_step_unit u_step (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    // corner table; entries past the depth are dropped
    assign w_we       = (r_state == S_SCAN) && w_rsp.kept && ({1'b0, r_total} < DEPTH_LIM);
    assign w_cnt_next = r_total + {7'd0, w_we};
    assign w_raddr    = (r_state == S_READ_A) ? r_a_addr : r_b_addr;

    scc_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_total[AW-1:0]),
        .i_wdata ({r_sy, r_sx}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // boundary target: nearer edge on the chain's axis
    assign w_near_lo = r_is_x ? ({r_cx, 1'b0} < {2'd0, w_dist}) :
                                ({r_cy, 1'b0} < {2'd0, w_dist});
    assign w_last    = w_rsp.done_next || (r_k == K_LAST);

    always_comb begin
        n_state     = r_state;
        n_dist      = r_dist;
        n_built     = r_built;
        n_xcount    = r_xcount;
        n_total     = r_total;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_pass      = r_pass;
        n_a_addr    = r_a_addr;
        n_b_addr    = r_b_addr;
        n_bnd       = r_bnd;
        n_is_x      = r_is_x;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_tx        = r_tx;
        n_ty        = r_ty;
        n_k         = r_k;
        n_out_valid = 1'b0;
        n_out       = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd.command == scc_pkg::CMD_BUILD) begin
                        n_total = 8'd0;
                        n_sx    = 4'd0;
                        n_sy    = 4'd0;
                        n_pass  = 1'b0;
                        n_state = S_SCAN;
                    end else if (w_range_err || w_type_err) begin
                        n_out            = '0;
                        n_out.error_flag = 1'b1;
                        n_out.last       = 1'b1;
                        n_out_valid      = 1'b1;
                    end else begin
                        n_a_addr = i_cmd.first_defect[AW-1:0];
                        n_b_addr = i_cmd.second_defect[AW-1:0];
                        n_bnd    = i_cmd.to_boundary;
                        n_is_x   = w_a_is_x;
                        n_k      = 4'd0;
                        n_state  = S_READ_A;
                    end
                end
            end
            S_SCAN: begin
                n_total = w_cnt_next;
                if (r_sx == w_dist) begin
                    n_sx = 4'd0;
                    if (r_sy == w_dist) begin
                        n_sy = 4'd0;
                        if (!r_pass) begin
                            n_pass   = 1'b1;
                            n_xcount = w_cnt_next;
                        end else begin
                            n_built                = 1'b1;
                            n_out                  = '0;
                            n_out.stabilizer_total = w_cnt_next;
                            n_out.last             = 1'b1;
                            n_out_valid            = 1'b1;
                            n_state                = S_IDLE;
                        end
                    end else begin
                        n_sy = r_sy + 4'd1;
                    end
                end else begin
                    n_sx = r_sx + 4'd1;
                end
            end
            S_READ_A: begin
                n_state = S_READ_B;
            end
            S_READ_B: begin
                n_cx    = {1'b0, w_rdata[3:0]};
                n_cy    = {1'b0, w_rdata[7:4]};
                n_state = S_LOAD_B;
            end
            S_LOAD_B: begin
                if (r_bnd) begin
                    n_tx = r_cx[3:0];
                    n_ty = r_cy[3:0];
                    if (r_is_x) begin
                        n_tx = w_near_lo ? 4'd0 : w_dist;
                    end else begin
                        n_ty = w_near_lo ? 4'd0 : w_dist;
                    end
                end else begin
                    n_tx = w_rdata[3:0];
                    n_ty = w_rdata[7:4];
                end
                n_state = S_WALK;
            end
            S_WALK: begin
                n_out           = '0;
                n_out.flip_kind = ~r_is_x;
                n_out_valid     = 1'b1;
                if ((r_k == 4'd0) && w_rsp.done_now) begin
                    // empty chain
                    n_out.last = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_out.qubit_index = w_rsp.qubit;
                    n_out.apply_flip  = w_rsp.ok;
                    n_out.last        = w_last;
                    n_cx              = w_rsp.nx;
                    n_cy              = w_rsp.ny;
                    n_k               = r_k + 4'd1;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (w_cfg_wr) begin
            n_dist  = pwdata[3:0];
            n_built = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dist      <= scc_pkg::DIST_RESET;
            r_built     <= 1'b0;
            r_xcount    <= 8'd0;
            r_total     <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dist      <= n_dist;
            r_built     <= n_built;
            r_xcount    <= n_xcount;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx     <= n_sx;
        r_sy     <= n_sy;
        r_pass   <= n_pass;
        r_a_addr <= n_a_addr;
        r_b_addr <= n_b_addr;
        r_bnd    <= n_bnd;
        r_is_x   <= n_is_x;
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_tx     <= n_tx;
        r_ty     <= n_ty;
        r_k      <= n_k;
        r_out    <= n_out;
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // an accepted word either starts work or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_result_valid)
        else $error("accepted word produced neither work nor result");

    // more words of the same item must follow
    a_not_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_result.last |-> busy)
        else $error("non-final result while idle");

    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.error_flag |->
            o_result.last && !o_result.apply_flip && (o_result.stabilizer_total == 8'd0))
        else $error("malformed error result");

    a_flip_in_lattice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.apply_flip |->
            !o_result.error_flag && (o_result.qubit_index <= QUBIT_MAX))
        else $error("flip outside lattice");

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps

// Checks the surface code correction chain engine: build words fill the corner
// table, walk words stream one result word per diagonal step.
module testbench;

    // cycles with no handshake of any kind before the run is abandoned;
    // the slowest build (d = 15) scans 512 corners without a result
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 62;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start   = 1'b0;
    logic                  busy;
    scc_pkg::t_cmd_word    i_cmd   = '0;
    logic                  o_result_valid;
    scc_pkg::t_result_word o_result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [2:0]            paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // mirror of the engine state, updated as each word is taken
    logic [7:0]   corner_mem [scc_pkg::TABLE_DEPTH_DEF];
    int           x_total    = 0;
    int           stab_total = 0;
    int           dist_cfg   = int'(scc_pkg::DIST_RESET);
    bit           layout_ok  = 1'b0;

    // result words still owed by the engine, oldest first
    scc_pkg::t_result_word chain_words[$];
    scc_pkg::t_result_word want_word;

    // run bookkeeping
    int  mismatch_count  = 0;
    int  results_checked = 0;
    int  sent_words      = 0;
    int  build_words     = 0;
    int  walk_words      = 0;
    int  distance_writes = 0;
    int  quiet_cycles    = 0;
    bit  idle_on         = 1'b1;
    int  gap_pct         = 25;

    surface_code_correction_path_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Chain predictor
    // ---------------------------------------------------------------

    function automatic bit in_lattice(int qx, int qy, int d);
        return qx >= 0 && qx < d && qy >= 0 && qy < d;
    endfunction

    // corner (x,y) survives as a plaquette of the wanted type
    function automatic bit corner_kept(int x, int y, int d, bit want_x);
        int n;
        bit is_x;
        n = int'(in_lattice(x - 1, y - 1, d)) + int'(in_lattice(x, y - 1, d)) +
            int'(in_lattice(x - 1, y, d)) + int'(in_lattice(x, y, d));
        is_x = ((x + y) % 2) == 0;
        if (is_x != want_x || (n != 2 && n != 4)) return 1'b0;
        // weight-2 plaquettes: X only on top/bottom, Z only on left/right
        if (n == 2 && is_x && (x == 0 || x == d)) return 1'b0;
        if (n == 2 && !is_x && (y == 0 || y == d)) return 1'b0;
        return 1'b1;
    endfunction

    // works out the result words of one accepted command word
    task automatic predict_chain(input scc_pkg::t_cmd_word w);
        scc_pkg::t_result_word held;
        int  d, a, b, n, pass, x, y, cx, cy, tx, ty, dx, dy, qx, qy, steps;
        bit  a_x, arrived, have_held;
        d = dist_cfg;
        a = int'(w.first_defect);
        b = int'(w.second_defect);
        a_x = a < x_total;
        held = '0;
        have_held = 1'b0;
        steps = 0;
        if (w.command == scc_pkg::CMD_BUILD) begin
            // X corners first, then Z, both in row order
            n = 0;
            x_total = 0;
            for (pass = 0; pass < 2; pass++) begin
                for (y = 0; y <= d; y++) begin
                    for (x = 0; x <= d; x++) begin
                        if (corner_kept(x, y, d, pass == 0) &&
                            n < scc_pkg::TABLE_DEPTH_DEF) begin
                            corner_mem[n] = 8'((y << 4) | x);
                            n++;
                        end
                    end
                end
                if (pass == 0) x_total = n;
            end
            stab_total = n;
            layout_ok = 1'b1;
            held.stabilizer_total = 8'(n);
        end else if (!layout_ok || a >= stab_total ||
                     (!w.to_boundary && (b >= stab_total || ((b < x_total) != a_x)))) begin
            held.error_flag = 1'b1;
        end else begin
            held.flip_kind = ~a_x;
            cx = int'(corner_mem[a][3:0]);
            cy = int'(corner_mem[a][7:4]);
            if (w.to_boundary) begin
                tx = cx;
                ty = cy;
                if (a_x) tx = (cx < d - cx) ? 0 : d;
                else ty = (cy < d - cy) ? 0 : d;
            end else begin
                tx = int'(corner_mem[b][3:0]);
                ty = int'(corner_mem[b][7:4]);
            end
            arrived = 1'b0;
            while (steps < scc_pkg::WALK_LIMIT && !arrived) begin
                if (w.to_boundary) arrived = a_x ? (cx == tx) : (cy == ty);
                else arrived = (cx == tx) && (cy == ty);
                if (!arrived) begin
                    if (w.to_boundary && a_x) begin
                        dx = (tx > cx) ? 1 : -1;
                        dy = 1;
                    end else if (w.to_boundary) begin
                        dx = 1;
                        dy = (ty > cy) ? 1 : -1;
                    end else begin
                        dx = (tx < cx) ? -1 : 1;
                        dy = (ty < cy) ? -1 : 1;
                    end
                    qx = (dx > 0) ? cx : cx - 1;
                    qy = (dy > 0) ? cy : cy - 1;
                    // previous step is not the last one, release it
                    if (have_held) chain_words = {chain_words, held};
                    held.apply_flip  = in_lattice(qx, qy, d);
                    held.qubit_index = held.apply_flip ? 8'(qy * d + qx) : 8'd0;
                    have_held = 1'b1;
                    steps++;
                    cx += dx;
                    cy += dy;
                end
            end
        end
        held.last = 1'b1;
        chain_words = {chain_words, held};
    endtask

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                      results_checked, name, got, want));
    endtask

    // results cannot be held off: every strobed word is taken at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) begin
            results_checked++;
            if (chain_words.size() == 0) begin
                report_mismatch($sformatf("result word %h with nothing pending", o_result));
            end else begin
                want_word = chain_words.pop_front();
                check_field("qubit_index", o_result.qubit_index, want_word.qubit_index);
                check_field("apply_flip", 8'(o_result.apply_flip), 8'(want_word.apply_flip));
                check_field("flip_kind", 8'(o_result.flip_kind), 8'(want_word.flip_kind));
                check_field("error_flag", 8'(o_result.error_flag), 8'(want_word.error_flag));
                check_field("stabilizer_total", o_result.stabilizer_total,
                            want_word.stabilizer_total);
                check_field("last", 8'(o_result.last), 8'(want_word.last));
            end
        end
    end

    // watchdog: any command, result or register handshake counts as progress
    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((start && busy === 1'b0) || o_result_valid === 1'b1 || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    function automatic scc_pkg::t_cmd_word make_word(input logic cmd,
                                                     input logic [7:0] a,
                                                     input logic [7:0] b,
                                                     input logic bnd);
        scc_pkg::t_cmd_word w;
        w.command = cmd;
        w.first_defect = a;
        w.second_defect = b;
        w.to_boundary = bnd;
        return w;
    endfunction

    // one command word; start stays up on return so back-to-back words
    // never see start dropped and raised in the same step
    task automatic send_word(input scc_pkg::t_cmd_word w);
        if (idle_on && $urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= w;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_chain(w);
        sent_words++;
        if (w.command == scc_pkg::CMD_BUILD) build_words++;
        else walk_words++;
    endtask

    // engine idle: nothing owed, busy low, plus a few cycles of margin
    task automatic wait_quiet();
        start <= 1'b0;
        while (chain_words.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write of code_distance, then a read back of the same register
    task automatic write_distance(input logic [3:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {scc_pkg::REG_CODE_DISTANCE, 2'b00};
        pwdata  <= {28'd0, d};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        dist_cfg = int'(d);
        layout_ok = 1'b0;
        distance_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata[3:0] !== d)
            report_mismatch($sformatf("code_distance read %0h want %0h", prdata[3:0], d));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // mostly well-formed walks on the current layout, some noise and rebuilds
    function automatic scc_pkg::t_cmd_word random_word();
        int sel, lo, hi;
        scc_pkg::t_cmd_word w;
        sel = $urandom_range(0, 99);
        w = make_word(scc_pkg::CMD_WALK, 8'($urandom), 8'($urandom), 1'b0);
        if (sel < 5) begin
            w.command = scc_pkg::CMD_BUILD;
            w.to_boundary = 1'($urandom);
        end else if (sel < 20 || stab_total == 0) begin
            w.to_boundary = 1'($urandom);
        end else if (sel < 45) begin
            w.first_defect = 8'($urandom_range(0, stab_total - 1));
            w.to_boundary = 1'b1;
        end else begin
            // same-type pair; a small share of the pairs cross types
            if ($urandom_range(0, 1) && x_total > 0) begin
                lo = 0;
                hi = x_total - 1;
            end else if (stab_total > x_total) begin
                lo = x_total;
                hi = stab_total - 1;
            end else begin
                lo = 0;
                hi = stab_total - 1;
            end
            w.first_defect = 8'($urandom_range(lo, hi));
            w.second_defect = (sel < 50) ? 8'($urandom_range(0, stab_total - 1))
                                         : 8'($urandom_range(lo, hi));
        end
        return w;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // walk with no layout is rejected; first build uses the reset distance
    task automatic test_reset_state();
        send_word(make_word(scc_pkg::CMD_WALK, 8'd0, 8'd0, 1'b1));
        send_word(make_word(scc_pkg::CMD_BUILD, 8'hFF, 8'hFF, 1'b1));
    endtask

    // every walk case at d = 3
    task automatic test_walk_cases();
        send_word(make_word(scc_pkg::CMD_WALK, 8'd0, 8'(x_total - 1), 1'b0));
        send_word(make_word(scc_pkg::CMD_WALK, 8'(x_total), 8'(stab_total - 1), 1'b0));
        // empty chain: partner equals first
        send_word(make_word(scc_pkg::CMD_WALK, 8'd1, 8'd1, 1'b0));
        // type mismatch
        send_word(make_word(scc_pkg::CMD_WALK, 8'd0, 8'(x_total), 1'b0));
        // indexes just and far out of range
        send_word(make_word(scc_pkg::CMD_WALK, 8'(stab_total), 8'd0, 1'b0));
        send_word(make_word(scc_pkg::CMD_WALK, 8'hFF, 8'd0, 1'b1));
        send_word(make_word(scc_pkg::CMD_WALK, 8'd0, 8'hFF, 1'b0));
        // partner ignored on a boundary walk
        send_word(make_word(scc_pkg::CMD_WALK, 8'd0, 8'hFF, 1'b1));
        send_word(make_word(scc_pkg::CMD_WALK, 8'(x_total - 1), 8'd0, 1'b1));
        send_word(make_word(scc_pkg::CMD_WALK, 8'(stab_total - 1), 8'd0, 1'b1));
    endtask

    // smallest and largest lattice; a distance write drops the layout
    task automatic test_distance_extremes();
        wait_quiet();
        write_distance(4'd2);
        send_word(make_word(scc_pkg::CMD_WALK, 8'd0, 8'd0, 1'b0));
        send_word(make_word(scc_pkg::CMD_BUILD, 8'd0, 8'd0, 1'b0));
        send_word(make_word(scc_pkg::CMD_WALK, 8'(x_total), 8'(stab_total - 1), 1'b0));
        send_word(make_word(scc_pkg::CMD_WALK, 8'd0, 8'd0, 1'b1));
        wait_quiet();
        write_distance(scc_pkg::MAX_DISTANCE);
        send_word(make_word(scc_pkg::CMD_BUILD, 8'd0, 8'd0, 1'b0));
        send_word(make_word(scc_pkg::CMD_WALK, 8'd0, 8'(x_total - 1), 1'b0));
        send_word(make_word(scc_pkg::CMD_WALK, 8'(x_total), 8'(stab_total - 1), 1'b0));
        send_word(make_word(scc_pkg::CMD_WALK, 8'(stab_total - 1), 8'hFF, 1'b1));
        send_word(make_word(scc_pkg::CMD_WALK, 8'(x_total - 1), 8'h00, 1'b1));
    endtask

    // random phases, one distance each; last phase runs with no gaps
    task automatic test_random_phases();
        int p, i;
        logic [3:0] d;
        for (p = 0; p < PHASES; p++) begin
            wait_quiet();
            if (p == 0) d = 4'd2;
            else if (p == 1) d = scc_pkg::MAX_DISTANCE;
            else d = 4'($urandom_range(2, 15));
            write_distance(d);
            idle_on = (p != PHASES - 1);
            gap_pct = $urandom_range(0, 45);
            if ($urandom_range(0, 1))
                send_word(make_word(scc_pkg::CMD_WALK, 8'($urandom), 8'($urandom),
                                    1'($urandom)));
            send_word(make_word(scc_pkg::CMD_BUILD, 8'($urandom), 8'($urandom),
                                1'($urandom)));
            for (i = 0; i < PHASE_WORDS; i++) send_word(random_word());
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_walk_cases();
        test_distance_extremes();
        test_random_phases();
        wait_quiet();
        repeat (24) @(posedge i_clk);
        if (chain_words.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived", chain_words.size()));
        $display("covered %0d command words (%0d builds, %0d walks), %0d distance writes",
                 sent_words, build_words, walk_words, distance_writes);
        $display("checked %0d result words, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
src/scc_pkg.sv
src/scc_ram.sv
src/scc_step_unit.sv
src/surface_code_correction_path_top.sv
dv/testbench.sv
